// File: rtl/olt_pkg.sv
package olt_pkg;

	// fixed field widths of one request and one result
	localparam int REQ_W  = 3;
	localparam int POS_W  = 5;
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;

	// stream widths; the tdata widths are padded to whole bytes
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = REQ_W;
	localparam int M_TDATA_W = 80;
	localparam int M_TUSER_W = STAT_W;

	// request codes
	localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FIND   = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

	// one stored list entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

endpackage

// File: rtl/olt_store.sv
module olt_store
	import olt_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// single registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/ordered_list_table.sv
// ordered list of up to DEPTH key/value entries at 1-based positions
//
// requests arrive on the s_ stream: s_tuser carries the request kind
// (append, insert, delete, read, find), s_tdata the position, key and value.
// each request gives exactly one result beat on the m_ stream: m_tuser holds
// the status, m_tdata the found position, entry and list length.
//
// all entries live in one memory with one write and one registered read
// port, so shifting and searching move one entry per cycle: insert at position p
// moves the entries from p to the end up by one and then writes the new entry,
// delete at position p moves the entries behind p down by one, and find reads
// from position 1 on until it hits the key or has read the last entry; append,
// read, failed checks and unused codes need no walk.
// s_tready is high only while no request is in flight.
//
// reset empties the list at once; no clearing pass is needed, as an entry is
// read only after it was written. while the receiver stalls the result beat
// is held in the output register; the next request may be taken meanwhile and
// its result waits until the output register is free.
module ordered_list_table
	import olt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // position[4:0], entry_key, entry_value
	input  logic [S_TUSER_W-1:0] s_tuser,  // req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // found_position, out_key, out_value, list_count
	output logic [M_TUSER_W-1:0] m_tuser   // status
);

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int M_PAD_W = M_TDATA_W - (POS_W + KEY_W + VAL_W + POS_W);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SHUP   = 7'b0000010,
		S_PUT    = 7'b0000100,
		S_SHDN   = 7'b0001000,
		S_RDWAIT = 7'b0010000,
		S_FIND   = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     len_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     tgt_q;
	entry_t               ent_q;
	logic [STAT_W-1:0]    res_status_q;
	logic [POS_W-1:0]     res_fpos_q;
	entry_t               res_ent_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic [REQ_W-1:0]     in_req;
	logic [POS_W-1:0]     in_pos;
	entry_t               in_ent;
	logic [CMP_W-1:0]     pos_c;
	logic [CMP_W-1:0]     len_c;
	logic                 acc;
	logic                 full;
	logic                 ins_bad;
	logic                 pos_bad;
	logic                 out_free;
	logic                 match;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	entry_t               mem_wdata;
	logic                 mem_re;
	logic [IDX_W-1:0]     mem_raddr;
	entry_t               mem_rdata;

	// request fields
	assign in_req       = s_tuser;
	assign in_pos       = s_tdata[4:0];
	assign in_ent.key   = s_tdata[36:5];
	assign in_ent.value = s_tdata[68:37];

	// position checks against the current length
	assign pos_c    = CMP_W'(in_pos);
	assign len_c    = CMP_W'(len_q);
	assign acc      = s_tvalid && s_tready;
	assign full     = (len_q == CNT_W'(DEPTH));
	assign ins_bad  = (pos_c == '0) || (pos_c > len_c + CMP_W'(1));
	assign pos_bad  = (pos_c == '0) || (pos_c > len_c);
	assign out_free = !m_tvalid_q || m_tready;
	assign match    = (mem_rdata.key == ent_q.key);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	olt_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (mem_re),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	// memory port control: one read and one write per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = ent_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					priority if (in_req == REQ_APPEND) begin
						if (!full) begin
							mem_we    = 1'b1;
							mem_waddr = len_q[IDX_W-1:0];
							mem_wdata = in_ent;
						end
					end else if (in_req == REQ_INSERT) begin
						if (!full && !ins_bad) begin
							if (pos_c == len_c + CMP_W'(1)) begin
								mem_we    = 1'b1;
								mem_waddr = len_q[IDX_W-1:0];
								mem_wdata = in_ent;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = IDX_W'(len_q - CNT_W'(1));
							end
						end
					end else if (in_req == REQ_DELETE) begin
						if (!pos_bad && pos_c != len_c) begin
							mem_re    = 1'b1;
							mem_raddr = IDX_W'(in_pos);
						end
					end else if (in_req == REQ_READ) begin
						if (!pos_bad) begin
							mem_re    = 1'b1;
							mem_raddr = IDX_W'(in_pos - POS_W'(1));
						end
					end else if (in_req == REQ_FIND) begin
						if (len_q != '0) begin
							mem_re    = 1'b1;
							mem_raddr = '0;
						end
					end else begin
						mem_re = 1'b0;
					end
				end
			end
			S_SHUP: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q + IDX_W'(1);
				mem_wdata = mem_rdata;
				if (idx_q != tgt_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q - IDX_W'(1);
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = tgt_q;
				mem_wdata = ent_q;
			end
			S_SHDN: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q - IDX_W'(1);
				mem_wdata = mem_rdata;
				if (idx_q != tgt_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + IDX_W'(1);
				end
			end
			S_FIND: begin
				if (!match && idx_q != tgt_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + IDX_W'(1);
				end
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// sequencer, list length and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						priority if (in_req == REQ_APPEND) begin
							if (!full) begin
								len_q <= len_q + CNT_W'(1);
							end
							state_q <= S_OUT;
						end else if (in_req == REQ_INSERT) begin
							if (!full && !ins_bad && pos_c != len_c + CMP_W'(1)) begin
								state_q <= S_SHUP;
							end else begin
								if (!full && !ins_bad) begin
									len_q <= len_q + CNT_W'(1);
								end
								state_q <= S_OUT;
							end
						end else if (in_req == REQ_DELETE) begin
							if (!pos_bad && pos_c != len_c) begin
								state_q <= S_SHDN;
							end else begin
								if (!pos_bad) begin
									len_q <= len_q - CNT_W'(1);
								end
								state_q <= S_OUT;
							end
						end else if (in_req == REQ_READ) begin
							state_q <= pos_bad ? S_OUT : S_RDWAIT;
						end else if (in_req == REQ_FIND) begin
							state_q <= (len_q != '0) ? S_FIND : S_OUT;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SHUP: begin
					if (idx_q == tgt_q) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					len_q   <= len_q + CNT_W'(1);
					state_q <= S_OUT;
				end
				S_SHDN: begin
					if (idx_q == tgt_q) begin
						len_q   <= len_q - CNT_W'(1);
						state_q <= S_OUT;
					end
				end
				S_RDWAIT: begin
					state_q <= S_OUT;
				end
				S_FIND: begin
					if (match || idx_q == tgt_q) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, walk index, result fields and output beat
	always_ff @(posedge clk) begin
		if (mem_re) begin
			idx_q <= mem_raddr;
		end
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					ent_q      <= in_ent;
					res_fpos_q <= '0;
					res_ent_q  <= '0;
					tgt_q      <= (in_req == REQ_INSERT) ? IDX_W'(in_pos - POS_W'(1)) :
						IDX_W'(len_q - CNT_W'(1));
					priority if (in_req == REQ_APPEND) begin
						res_status_q <= full ? STAT_FULL : STAT_OK;
					end else if (in_req == REQ_INSERT) begin
						if (full) begin
							res_status_q <= STAT_FULL;
						end else if (ins_bad) begin
							res_status_q <= STAT_BADPOS;
						end else begin
							res_status_q <= STAT_OK;
						end
					end else if (in_req == REQ_DELETE || in_req == REQ_READ) begin
						res_status_q <= pos_bad ? STAT_BADPOS : STAT_OK;
					end else if (in_req == REQ_FIND) begin
						res_status_q <= (len_q == '0) ? STAT_NOTFOUND : STAT_OK;
					end else begin
						res_status_q <= STAT_OK;
					end
				end
			end
			S_RDWAIT: begin
				res_ent_q <= mem_rdata;
			end
			S_FIND: begin
				if (match) begin
					res_fpos_q <= POS_W'(CNT_W'(idx_q) + CNT_W'(1));
					res_ent_q  <= mem_rdata;
				end else if (idx_q == tgt_q) begin
					res_status_q <= STAT_NOTFOUND;
				end
			end
			S_OUT: begin
				if (out_free) begin
					m_tdata_q <= {{M_PAD_W{1'b0}}, POS_W'(len_q), res_ent_q.value,
						res_ent_q.key, res_fpos_q};
					m_tuser_q <= res_status_q;
				end
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
	end

endmodule

// File: rtl/olt_checker.sv
module olt_checker
	import olt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	// a stalled result beat keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one request at a time: no new beat taken right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// failed requests carry no position and no entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_FULL || m_tuser == STAT_BADPOS ||
			m_tuser == STAT_NOTFOUND)
		|-> m_tdata[4:0] == '0 && m_tdata[36:5] == '0 && m_tdata[68:37] == '0)
		else $error("failed result carries entry data");

	// a full report only comes with a full list
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_FULL |-> m_tdata[73:69] == POS_W'(DEPTH))
		else $error("full status with list not full");

	// a not-found report cannot coexist with a found position
	a_find_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:0] != '0 |-> m_tuser == STAT_OK)
		else $error("found position with failing status");

endmodule

bind ordered_list_table olt_checker #(.DEPTH(DEPTH)) u_olt_checker (.*);
